@@ hw/rtl/cbm_pkg.sv @@
// Package with shared types and constants of the bank mapper.
`default_nettype none
package cbm_pkg;
  localparam logic [2:0] CMD_CPU_READ  = 3'd0;
  localparam logic [2:0] CMD_CPU_WRITE = 3'd1;
  localparam logic [2:0] CMD_PPU_READ  = 3'd2;
  localparam logic [2:0] CMD_PPU_WRITE = 3'd3;
  localparam logic [2:0] CMD_PPU_DOT   = 3'd4;
  localparam logic [2:0] CMD_M2_TICK   = 3'd5;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_RAM  = 2'd1;
  localparam logic [1:0] TGT_ROM  = 2'd2;
  localparam logic [1:0] TGT_CHR  = 2'd3;

  localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
  localparam logic [1:0] CFG_RAM       = 2'd2;
  localparam logic [1:0] CFG_FOUR      = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic        handled;
    logic [1:0]  memory_target;
    logic [20:0] memory_offset;
    logic        memory_write;
    logic [7:0]  memory_data;
    logic        irq_out;
    logic [1:0]  nametable_mirroring;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item and pick a bank
    logic mod_start; // start the bank reduction
    logic finish;    // form the result and update state
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
  } dp_status_t;
endpackage
`default_nettype wire

@@ hw/rtl/cbm_stream_if.sv @@
// Valid/ready stream interfaces for items, results and configuration writes.
`default_nettype none
interface cbm_in_if;
  logic valid;
  logic ready;
  cbm_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cbm_out_if;
  logic valid;
  logic ready;
  cbm_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface cbm_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/cbm_datapath.sv @@
// Datapath: bank selection, serial bank reduction, offsets and IRQ counter.
`default_nettype none
module cbm_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cbm_pkg::in_item_t    item,
  input  wire cbm_pkg::dp_cmd_t     cmd,
  output cbm_pkg::dp_status_t       status,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [8:0]           cfg_data,
  output cbm_pkg::out_item_t        result
);
  logic [8:0] prg_bank_count, chr_bank_count;
  logic       prg_ram_present, four_screen;

  logic [3:0] bank_index;
  logic [7:0] bank_registers [16];
  logic       chr_single_kb_mode, prg_swap_mode, chr_swap_mode;
  logic [7:0] irq_reload_value, irq_count;
  logic       irq_enable, irq_reload_pending, irq_cycle_mode;
  logic [1:0] tick_prescale;
  logic       previous_a12;
  logic [3:0] a12_low_dots;
  logic       horiz_mirror, irq_level;

  cbm_pkg::in_item_t it;
  logic [8:0] bank_sel;
  logic [8:0] divisor;
  // Restoring reduction: remainder and shifted divisor over 9 steps.
  logic [17:0] rem, dsh;
  logic [3:0]  step;
  logic        busy;

  // Bank choice for the current item.
  logic [8:0] bank_pick;
  logic [1:0] region;
  logic [2:0] slot;
  logic [7:0] pr;
  always_comb begin
    region = item.address[14:13];
    slot = item.address[12:10] ^ {chr_swap_mode, 2'b00};
    pr = bank_registers[{3'b000, slot[1]}];
    bank_pick = '0;
    if (item.command == cbm_pkg::CMD_CPU_READ || item.command == cbm_pkg::CMD_CPU_WRITE) begin
      unique case (region)
        2'd0: bank_pick = {1'b0, prg_swap_mode ? bank_registers[15] : bank_registers[6]};
        2'd1: bank_pick = {1'b0, prg_swap_mode ? bank_registers[6] : bank_registers[7]};
        2'd2: bank_pick = {1'b0, prg_swap_mode ? bank_registers[7] : bank_registers[15]};
        default: bank_pick = prg_bank_count - 9'd1;
      endcase
    end else begin
      if (!slot[2]) begin
        if (chr_single_kb_mode)
          bank_pick = {1'b0, slot[0] ? bank_registers[{3'b100, slot[1]}] : pr};
        else
          bank_pick = {1'b0, slot[0] ? (pr | 8'h01) : (pr & 8'hFE)};
      end else begin
        bank_pick = {1'b0, bank_registers[{2'b00, slot[1:0]} + 4'd2]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= item;
      bank_sel <= bank_pick;
      divisor <= (item.command == cbm_pkg::CMD_CPU_READ ||
                  item.command == cbm_pkg::CMD_CPU_WRITE) ? prg_bank_count : chr_bank_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (cmd.mod_start) begin
      busy <= 1'b1;
      step <= 4'd8;
      rem <= {9'd0, bank_sel};
      dsh <= {1'b0, divisor, 8'd0};
    end else if (busy) begin
      if (rem >= dsh) rem <= rem - dsh;
      dsh <= dsh >> 1;
      if (step == 4'd0) busy <= 1'b0;
      else step <= step - 4'd1;
    end
  end
  assign status.mod_done = !busy && !cmd.mod_start;

  // A zero divisor makes the remainder meaningless but the access is then unmapped.
  logic [7:0] bank_red;
  assign bank_red = rem[7:0];

  logic is_cpu, is_ppu, a12;
  logic [7:0] cnt_after;
  logic       clock_ctr;
  always_comb begin
    is_cpu = it.command == cbm_pkg::CMD_CPU_READ || it.command == cbm_pkg::CMD_CPU_WRITE;
    is_ppu = it.command == cbm_pkg::CMD_PPU_READ || it.command == cbm_pkg::CMD_PPU_WRITE;
    a12 = it.address[12];
    clock_ctr = 1'b0;
    if (it.command == cbm_pkg::CMD_PPU_DOT)
      clock_ctr = a12 && !previous_a12 && a12_low_dots >= 4'd8 && !irq_cycle_mode;
    else if (it.command == cbm_pkg::CMD_M2_TICK)
      clock_ctr = irq_cycle_mode && tick_prescale == 2'd3;
    cnt_after = (irq_count == 8'd0 || irq_reload_pending) ? irq_reload_value
                                                          : irq_count - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= 9'd16;
      chr_bank_count <= 9'd0;
      prg_ram_present <= 1'b1;
      four_screen <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbm_pkg::CFG_PRG_COUNT: prg_bank_count <= cfg_data;
        cbm_pkg::CFG_CHR_COUNT: chr_bank_count <= cfg_data;
        cbm_pkg::CFG_RAM:       prg_ram_present <= cfg_data[0];
        default:                four_screen <= cfg_data[0];
      endcase
    end
  end

  logic irq_level_next;
  always_comb begin
    irq_level_next = irq_level;
    if (is_cpu && it.command == cbm_pkg::CMD_CPU_WRITE && it.address[15] &&
        {it.address[15:13], it.address[0]} == 4'b1110)
      irq_level_next = 1'b0;
    if (clock_ctr && cnt_after == 8'd0 && irq_enable) irq_level_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_index <= '0;
      for (int i = 0; i < 16; i++) bank_registers[i] <= '0;
      chr_single_kb_mode <= 1'b0;
      prg_swap_mode <= 1'b0;
      chr_swap_mode <= 1'b0;
      irq_reload_value <= '0;
      irq_count <= '0;
      irq_enable <= 1'b0;
      irq_reload_pending <= 1'b0;
      irq_cycle_mode <= 1'b0;
      tick_prescale <= '0;
      previous_a12 <= 1'b0;
      a12_low_dots <= '0;
      horiz_mirror <= 1'b0;
      irq_level <= 1'b0;
    end else if (cmd.finish) begin
      irq_level <= irq_level_next;
      if (clock_ctr) begin
        irq_count <= cnt_after;
        irq_reload_pending <= 1'b0;
      end
      if (it.command == cbm_pkg::CMD_CPU_WRITE && it.address[15]) begin
        unique case ({it.address[14:13], it.address[0]})
          3'b000: begin
            bank_index <= it.write_data[3:0];
            chr_single_kb_mode <= it.write_data[5];
            prg_swap_mode <= it.write_data[6];
            chr_swap_mode <= it.write_data[7];
          end
          3'b001: bank_registers[bank_index] <= it.write_data;
          3'b010: if (!four_screen) horiz_mirror <= it.write_data[0];
          3'b100: irq_reload_value <= it.write_data;
          3'b101: begin
            irq_cycle_mode <= it.write_data[0];
            irq_reload_pending <= 1'b1;
            tick_prescale <= '0;
          end
          3'b110: irq_enable <= 1'b0;
          3'b111: irq_enable <= 1'b1;
          default: ;
        endcase
      end
      if (it.command == cbm_pkg::CMD_PPU_DOT) begin
        if (!a12) begin
          if (a12_low_dots < 4'd8) a12_low_dots <= a12_low_dots + 4'd1;
        end else begin
          a12_low_dots <= '0;
        end
        previous_a12 <= a12;
      end
      if (it.command == cbm_pkg::CMD_M2_TICK && irq_cycle_mode)
        tick_prescale <= tick_prescale + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.handled <= 1'b0;
      result.memory_target <= cbm_pkg::TGT_NONE;
      result.memory_offset <= '0;
      result.memory_write <= 1'b0;
      result.memory_data <= '0;
      if (is_cpu) begin
        if (it.address[15:13] == 3'b011) begin
          result.handled <= 1'b1;
          if (prg_ram_present) begin
            result.memory_target <= cbm_pkg::TGT_RAM;
            result.memory_offset <= {8'd0, it.address[12:0]};
            if (it.command == cbm_pkg::CMD_CPU_WRITE) begin
              result.memory_write <= 1'b1;
              result.memory_data <= it.write_data;
            end
          end
        end else if (it.address[15]) begin
          result.handled <= 1'b1;
          if (it.command == cbm_pkg::CMD_CPU_READ && prg_bank_count != 9'd0) begin
            result.memory_target <= cbm_pkg::TGT_ROM;
            result.memory_offset <= {bank_red, it.address[12:0]};
          end
        end
      end else if (is_ppu && it.address[15:13] == 3'b000 && chr_bank_count != 9'd0) begin
        result.handled <= 1'b1;
        result.memory_target <= cbm_pkg::TGT_CHR;
        result.memory_offset <= {3'd0, bank_red, it.address[9:0]};
        if (it.command == cbm_pkg::CMD_PPU_WRITE) begin
          result.memory_write <= 1'b1;
          result.memory_data <= it.write_data;
        end
      end
      result.irq_out <= irq_level_next;
      result.nametable_mirroring <= four_screen ? 2'd2 :
        {1'b0, (it.command == cbm_pkg::CMD_CPU_WRITE && it.address[15] &&
                {it.address[14:13], it.address[0]} == 3'b010) ? it.write_data[0]
                                                             : horiz_mirror};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/cbm_controller.sv @@
// Controller state machine sequencing one item through the datapath.
`default_nettype none
module cbm_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cbm_pkg::dp_cmd_t         cmd,
  input  wire cbm_pkg::dp_status_t status
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_START = 4'b0010, S_REDUCE = 4'b0100, S_FINISH = 4'b1000
  } state_t;
  state_t state, state_next;
  logic out_valid_next;

  // The result register is free if empty or taken this cycle.
  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.mod_start = 1'b1;
        state_next = S_REDUCE;
      end
      S_REDUCE: if (status.mod_done) state_next = S_FINISH;
      S_FINISH: if (out_free) begin
        cmd.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/cartridge_bank_mapper_with_irq_counter.sv @@
// Top level of the cartridge bank mapper with its interrupt counter.
// Usage:
// The block takes bus items (CPU read or write, PPU read or write, PPU dot,
// M2 tick) on the in channel and returns exactly one result transaction per
// item on the out channel. Configuration registers (bank counts, work RAM
// presence, four-screen lock) are written over the cfg channel, which is
// always ready; write it only while no item is in flight.
// Operation: an item is taken in the idle state, then the bank
// number is reduced by a restoring remainder unit that handles one quotient
// bit a cycle, and the result register is loaded. The next item can be
// accepted in the cycle after the result is loaded, so the block works on
// one item at a time.
// A stalled receiver holds the result in the output register; the
// controller waits in its final state until that register frees up.
// Synchronous reset clears all mapper state, restores the register defaults
// (16 PRG banks, no CHR banks, work RAM present, mirroring unlocked) and
// empties the output register.
`default_nettype none
module cartridge_bank_mapper_with_irq_counter (
  input  wire logic  clk,
  input  wire logic  rst,
  cbm_in_if.sink     in_ch,
  cbm_out_if.source  out_ch,
  cbm_cfg_if.sink    cfg
);
  cbm_pkg::dp_cmd_t    cmd;
  cbm_pkg::dp_status_t status;

  // Configuration writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  cbm_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .status(status)
  );

  cbm_datapath u_dp (
    .clk(clk), .rst(rst),
    .item(in_ch.payload), .cmd(cmd), .status(status),
    .cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .result(out_ch.payload)
  );
endmodule
`default_nettype wire
